// File: src/housekeeping_count_to_units_defines.svh
// Assertion macros used by the housekeeping conversion checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef HOUSEKEEPING_COUNT_TO_UNITS_DEFINES_SVH
`define HOUSEKEEPING_COUNT_TO_UNITS_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define HKCU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define HKCU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: src/hkcu_pkg.sv
// Types, constants and the cubic conversion function of the housekeeping converter.
// No dependencies; the interfaces, the converter and the checker import this package.
`timescale 1ns / 1ps

package hkcu_pkg;

  // Field widths.
  localparam int CH_W     = 4;
  localparam int CH_N     = 16;
  localparam int CNT_W    = 8;
  localparam int CNT_N    = 256;
  localparam int VALUE_W  = 19;

  // Output range.
  localparam int VALUE_MAX   = 2 ** (VALUE_W - 1) - 1;
  localparam int SAT_NEG_MAG = 2 ** (VALUE_W - 1);
  localparam logic signed [VALUE_W-1:0] VALUE_LO = {1'b1, {(VALUE_W - 1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VALUE_HI = {1'b0, {(VALUE_W - 1){1'b1}}};

  // Marker answered by temperature channels that have no conversion.
  localparam int MARK_UNITS = -999;

  // Bank codes.
  localparam logic KIND_SUPPLY = 1'b0;
  localparam logic KIND_TEMP   = 1'b1;

  // Temperature bank channels with a conversion law.
  localparam logic [CH_W-1:0] CH_T_POLY_A  = 4'd3;
  localparam logic [CH_W-1:0] CH_T_POLY_B0 = 4'd7;
  localparam logic [CH_W-1:0] CH_T_POLY_B1 = 4'd8;
  localparam logic [CH_W-1:0] CH_T_POLY_B2 = 4'd9;
  localparam logic [CH_W-1:0] CH_T_LINEAR  = 4'd11;

  // Linear law datapath widths: num = a*count - b*partner + c, value = num / d.
  localparam int COEF_A_W  = 17;
  localparam int COEF_B_W  = 14;
  localparam int COEF_C_W  = 24;
  localparam int NUM_W     = 26;
  localparam int MAG_W     = 25;
  localparam int DEN_W     = 16;
  localparam int QUO_W     = 14;
  localparam int REC_W     = 33;
  localparam int REC_SHIFT = 44;

  // Reciprocals ceil(2^REC_SHIFT / d); exact for every dividend below 2^28.
  localparam longint unsigned REC_ONE = 64'd1 << REC_SHIFT;
  localparam logic [REC_W-1:0] REC_9486  = REC_W'((REC_ONE + 64'd9485) / 64'd9486);
  localparam logic [REC_W-1:0] REC_15504 = REC_W'((REC_ONE + 64'd15503) / 64'd15504);
  localparam logic [REC_W-1:0] REC_3417  = REC_W'((REC_ONE + 64'd3416) / 64'd3417);
  localparam logic [REC_W-1:0] REC_49725 = REC_W'((REC_ONE + 64'd49724) / 64'd49725);
  localparam logic [REC_W-1:0] REC_5100  = REC_W'((REC_ONE + 64'd5099) / 64'd5100);
  localparam logic [REC_W-1:0] REC_51000 = REC_W'((REC_ONE + 64'd50999) / 64'd51000);

  typedef struct packed {
    logic [COEF_A_W-1:0]        a;
    logic [COEF_B_W-1:0]        b;
    logic signed [COEF_C_W-1:0] c;
    logic [DEN_W-1:0]           d;
    logic [REC_W-1:0]           r;
  } law_t;

  // Supply bank: volts are count/51, then divisor or gain, partner rail on 12 to 15.
  localparam law_t SUPPLY_LAWS [CH_N] = '{
    '{17'd10000,  14'd0,     24'sd0, 16'd9486,  REC_9486},
    '{17'd10000,  14'd0,     24'sd0, 16'd15504, REC_15504},
    '{17'd1000,   14'd0,     24'sd0, 16'd3417,  REC_3417},
    '{17'd100000, 14'd0,     24'sd0, 16'd49725, REC_49725},
    '{17'd122,    14'd0,     24'sd0, 16'd5100,  REC_5100},
    '{17'd148,    14'd0,     24'sd0, 16'd5100,  REC_5100},
    '{17'd285,    14'd0,     24'sd0, 16'd5100,  REC_5100},
    '{17'd148,    14'd0,     24'sd0, 16'd5100,  REC_5100},
    '{17'd123,    14'd0,     24'sd0, 16'd5100,  REC_5100},
    '{17'd1110,   14'd0,     24'sd0, 16'd5100,  REC_5100},
    '{17'd321,    14'd0,     24'sd0, 16'd5100,  REC_5100},
    '{17'd122,    14'd0,     24'sd0, 16'd5100,  REC_5100},
    '{17'd3200,   14'd3245,  24'sd0, 16'd51000, REC_51000},
    '{17'd2460,   14'd4140,  24'sd0, 16'd51000, REC_51000},
    '{17'd3200,   14'd3250,  24'sd0, 16'd51000, REC_51000},
    '{17'd2100,   14'd13140, 24'sd0, 16'd51000, REC_51000}
  };

  // Temperature linear law (0.78x - 98.5), numerator and denominator scaled by 51.
  localparam law_t LINEAR_LAW = '{17'd39780, 14'd0, -24'sd5023500, 16'd51000, REC_51000};

  // The marker goes through the same divider path as marker * 5100 / 5100.
  localparam law_t MARK_LAW = '{17'd0, 14'd0, COEF_C_W'(MARK_UNITS * 5100), 16'd5100,
                                REC_5100};

  // Cubic laws in the raw count, reduced to lowest common terms.
  localparam longint CUB_A_C0  = 64'sd11932270000;
  localparam longint CUB_A_C1  = -64'sd153005950;
  localparam longint CUB_A_C2  = 64'sd922500;
  localparam longint CUB_A_C3  = -64'sd2561;
  localparam longint CUB_A_DEN = 64'sd100000000;
  localparam longint CUB_B_C0  = 64'sd321390895000000;
  localparam longint CUB_B_C1  = -64'sd4420325850000;
  localparam longint CUB_B_C2  = 64'sd26976404500;
  localparam longint CUB_B_C3  = -64'sd65467239;
  localparam longint CUB_B_DEN = 64'sd2500000000000;

  // Fixed-point value of a cubic law at one count: rounded half away from zero,
  // then saturated. Evaluated at elaboration to fill the lookup tables.
  function automatic logic signed [VALUE_W-1:0] cubic_fix(input logic law_b,
                                                          input longint x,
                                                          input int frac);
    longint          num;
    longint unsigned mag;
    longint unsigned m;
    logic            neg;
    if (law_b) begin
      num = CUB_B_C0 + CUB_B_C1 * x + CUB_B_C2 * x * x + CUB_B_C3 * x * x * x;
    end else begin
      num = CUB_A_C0 + CUB_A_C1 * x + CUB_A_C2 * x * x + CUB_A_C3 * x * x * x;
    end
    neg = (num < 0);
    mag = neg ? longint'(-num) : longint'(num);
    if (law_b) begin
      m = ((mag << frac) + CUB_B_DEN / 2) / CUB_B_DEN;
    end else begin
      m = ((mag << frac) + CUB_A_DEN / 2) / CUB_A_DEN;
    end
    if (m > longint'(SAT_NEG_MAG)) begin
      m = longint'(SAT_NEG_MAG);
    end
    if (neg) begin
      return VALUE_W'(-longint'(m));
    end else if (m > longint'(VALUE_MAX)) begin
      return VALUE_HI;
    end else begin
      return VALUE_W'(m);
    end
  endfunction

endpackage

// File: src/hkcu_if.sv
// Valid/ready channel interfaces for the housekeeping converter: raw count in,
// converted value out. Depends on hkcu_pkg for the field widths.
`timescale 1ns / 1ps

interface hkcu_in_if import hkcu_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [CH_W-1:0]  channel;
  logic [CNT_W-1:0] sample;
  logic [CNT_W-1:0] partner_sample;

  modport source (output valid, kind, channel, sample, partner_sample, input ready);
  modport sink (input valid, kind, channel, sample, partner_sample, output ready);
endinterface

interface hkcu_out_if import hkcu_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      unsupported;

  modport source (output valid, value, unsupported, input ready);
  modport sink (input valid, value, unsupported, output ready);
endinterface

// File: src/housekeeping_count_to_units.sv
// Housekeeping count to engineering units, five-stage pipeline.
// Throughput: one item per cycle while the output is ready; the two reciprocal multiplies of the divider set the depth.
// Cubic laws are read from elaborated 256-entry tables and ride alongside the divider.
// Reset (rst, synchronous) clears all stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps

module housekeeping_count_to_units import hkcu_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  hkcu_in_if.sink     raw,
  hkcu_out_if.source  conv
);

  localparam int X2_W = DEN_W + FRAC_BITS + 1;
  localparam int F_W  = FRAC_BITS + 1;
  localparam int M_W  = QUO_W + FRAC_BITS + 1;
  localparam int P1_W = MAG_W + REC_W;
  localparam int P2_W = X2_W + REC_W;
  localparam int QD_W = QUO_W + DEN_W;

  // Cubic lookup tables, filled at elaboration.
  logic signed [VALUE_W-1:0] cub_a_rom [CNT_N];
  logic signed [VALUE_W-1:0] cub_b_rom [CNT_N];

  for (genvar gi = 0; gi < CNT_N; gi++) begin : g_rom
    localparam logic signed [VALUE_W-1:0] A_ENTRY = cubic_fix(1'b0, gi, FRAC_BITS);
    localparam logic signed [VALUE_W-1:0] B_ENTRY = cubic_fix(1'b1, gi, FRAC_BITS);
    assign cub_a_rom[gi] = A_ENTRY;
    assign cub_b_rom[gi] = B_ENTRY;
  end

  // Stage valid bits and advance enables.
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  // A stage advances when it is empty or the stage after it advances.
  assign en5 = !v5 || conv.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign raw.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= raw.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Stage 1: pick the law, form the signed numerator, read the cubic tables.
  law_t                        law;
  logic                        cub_hit;
  logic                        cub_b;
  logic                        unsup;
  logic [COEF_A_W+CNT_W-1:0]   prod_a;
  logic [COEF_B_W+CNT_W-1:0]   prod_b;
  logic signed [NUM_W-1:0]     num;
  logic signed [VALUE_W-1:0]   cub_val;

  always_comb begin
    law     = MARK_LAW;
    cub_hit = 1'b0;
    cub_b   = 1'b0;
    unsup   = 1'b0;
    if (raw.kind == KIND_SUPPLY) begin
      law = SUPPLY_LAWS[raw.channel];
    end else begin
      case (raw.channel)
        CH_T_POLY_A: begin
          cub_hit = 1'b1;
        end
        CH_T_POLY_B0, CH_T_POLY_B1, CH_T_POLY_B2: begin
          cub_hit = 1'b1;
          cub_b   = 1'b1;
        end
        CH_T_LINEAR: begin
          law = LINEAR_LAW;
        end
        default: begin
          unsup = 1'b1;
        end
      endcase
    end
    prod_a  = (COEF_A_W + CNT_W)'(law.a) * (COEF_A_W + CNT_W)'(raw.sample);
    prod_b  = (COEF_B_W + CNT_W)'(law.b) * (COEF_B_W + CNT_W)'(raw.partner_sample);
    num     = NUM_W'($signed({1'b0, prod_a})) - NUM_W'($signed({1'b0, prod_b}))
              + NUM_W'(law.c);
    cub_val = cub_b ? cub_b_rom[raw.sample] : cub_a_rom[raw.sample];
  end

  logic signed [NUM_W-1:0]   num1;
  logic [DEN_W-1:0]          d1;
  logic [REC_W-1:0]          r1;
  logic                      hit1;
  logic signed [VALUE_W-1:0] tab1;
  logic                      uns1;

  always_ff @(posedge clk) begin
    if (en1) begin
      num1 <= num;
      d1   <= law.d;
      r1   <= law.r;
      hit1 <= cub_hit;
      tab1 <= cub_val;
      uns1 <= unsup;
    end
  end

  // Stage 2: integer quotient of the magnitude by reciprocal multiply.
  logic [MAG_W-1:0] mag;
  logic [P1_W-1:0]  prod1;

  always_comb begin
    mag   = (num1 < 0) ? MAG_W'(-num1) : MAG_W'(num1);
    prod1 = P1_W'(mag) * P1_W'(r1);
  end

  logic [MAG_W-1:0]          mag2;
  logic [QUO_W-1:0]          q2;
  logic                      neg2;
  logic [DEN_W-1:0]          d2;
  logic [REC_W-1:0]          r2;
  logic                      hit2;
  logic signed [VALUE_W-1:0] tab2;
  logic                      uns2;

  always_ff @(posedge clk) begin
    if (en2) begin
      mag2 <= mag;
      q2   <= prod1[REC_SHIFT +: QUO_W];
      neg2 <= (num1 < 0);
      d2   <= d1;
      r2   <= r1;
      hit2 <= hit1;
      tab2 <= tab1;
      uns2 <= uns1;
    end
  end

  // Stage 3: remainder of the integer division.
  logic [QD_W-1:0]  qd;
  logic [MAG_W-1:0] rem;

  always_comb begin
    qd  = QD_W'(q2) * QD_W'(d2);
    rem = mag2 - qd[MAG_W-1:0];
  end

  logic [DEN_W-1:0]          rem3;
  logic [QUO_W-1:0]          q3;
  logic                      neg3;
  logic [DEN_W-1:0]          d3;
  logic [REC_W-1:0]          r3;
  logic                      hit3;
  logic signed [VALUE_W-1:0] tab3;
  logic                      uns3;

  always_ff @(posedge clk) begin
    if (en3) begin
      rem3 <= rem[DEN_W-1:0];
      q3   <= q2;
      neg3 <= neg2;
      d3   <= d2;
      r3   <= r2;
      hit3 <= hit2;
      tab3 <= tab2;
      uns3 <= uns2;
    end
  end

  // Stage 4: rounded fraction, (rem * 2^F + d/2) / d by reciprocal multiply.
  logic [X2_W-1:0] x2;
  logic [P2_W-1:0] prod2;

  always_comb begin
    x2    = (X2_W'(rem3) << FRAC_BITS) + X2_W'(d3 >> 1);
    prod2 = P2_W'(x2) * P2_W'(r3);
  end

  logic [F_W-1:0]            f4;
  logic [QUO_W-1:0]          q4;
  logic                      neg4;
  logic                      hit4;
  logic signed [VALUE_W-1:0] tab4;
  logic                      uns4;

  always_ff @(posedge clk) begin
    if (en4) begin
      f4   <= prod2[REC_SHIFT +: F_W];
      q4   <= q3;
      neg4 <= neg3;
      hit4 <= hit3;
      tab4 <= tab3;
      uns4 <= uns3;
    end
  end

  // Stage 5: join quotient and fraction, apply sign and saturate, or take the cubic table value.
  logic [M_W-1:0]            m;
  logic signed [VALUE_W-1:0] sat_val;
  logic signed [VALUE_W-1:0] value_next;

  always_comb begin
    m = (M_W'(q4) << FRAC_BITS) + M_W'(f4);
    if (neg4) begin
      if (m > M_W'(SAT_NEG_MAG)) begin
        sat_val = VALUE_LO;
      end else begin
        sat_val = -$signed(m[VALUE_W-1:0]);
      end
    end else if (m > M_W'(VALUE_MAX)) begin
      sat_val = VALUE_HI;
    end else begin
      sat_val = $signed(m[VALUE_W-1:0]);
    end
    value_next = hit4 ? tab4 : sat_val;
  end

  logic signed [VALUE_W-1:0] val5;
  logic                      uns5;

  always_ff @(posedge clk) begin
    if (en5) begin
      val5 <= value_next;
      uns5 <= uns4;
    end
  end

  assign conv.valid       = v5;
  assign conv.value       = val5;
  assign conv.unsupported = uns5;

endmodule

// File: src/hkcu_checker.sv
// Port-level checks for the housekeeping converter, bound onto the top level.
// Depends on hkcu_pkg and the assertion macros in the defines header.
`timescale 1ns / 1ps
`include "housekeeping_count_to_units_defines.svh"

module hkcu_checker import hkcu_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [VALUE_W-1:0] value,
  input logic                      unsupported
);

  // Expected marker value after scaling and saturation.
  localparam longint MARK_FULL = longint'(MARK_UNITS) * (longint'(1) << FRAC_BITS);
  localparam logic signed [VALUE_W-1:0] MARK =
    (MARK_FULL < -longint'(SAT_NEG_MAG)) ? VALUE_LO : VALUE_W'(MARK_FULL);

  // A stalled result keeps its value.
  `HKCU_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
                    out_valid && $stable(value) && $stable(unsupported))

  // An unsupported channel always answers the scaled marker.
  `HKCU_ASSERT_NOW(a_unsup_marker, out_valid && unsupported, value == MARK)

  // The pipeline comes out of reset empty.
  `HKCU_ASSERT_NOW(a_reset_empty, $fell(rst), !out_valid)

  // A draining output never holds back the input side.
  `HKCU_ASSERT_NOW(a_no_input_stall, out_ready, in_ready)

  // With the output draining, an accepted item reaches the output register in time.
  `HKCU_ASSERT_NEXT(a_latency,
                    in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready
                    ##1 out_ready ##1 out_ready,
                    out_valid)

endmodule

bind housekeeping_count_to_units hkcu_checker #(.FRAC_BITS(FRAC_BITS)) u_hkcu_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (raw.valid),
  .in_ready    (raw.ready),
  .out_valid   (conv.valid),
  .out_ready   (conv.ready),
  .value       (conv.value),
  .unsupported (conv.unsupported)
);
